[rtl/tpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tpt_pkg;

	localparam int DEF_TABLE_DEPTH = 32;
	localparam int DEF_OWNER_BITS  = 16;

	localparam int CMD_W    = 3;
	localparam int OWNER_W  = 16;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 6;

	localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ_FIRST = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FIRST  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COUNT_DATE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DROP_OWNER = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

	// timestamp, most significant field first so the packed value orders in time
	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [5:0]  hour;
		logic [5:0]  minute;
	} key_t;

	localparam int KEY_W = $bits(key_t);
	typedef logic [KEY_W-1:0] key_bits_t;

	// per-cell controls
	typedef struct packed {
		logic wr;
		logic shift;
		logic kill_set;
		logic kill_clr;
	} cell_ctl_t;

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		unique case (m)
			4'd2:                      r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/tpt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface tpt_req_if;
	import tpt_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [OWNER_W-1:0] owner_id;
	logic [4:0]         day;
	logic [3:0]         month;
	logic [13:0]        year;
	logic [5:0]         hour;
	logic [5:0]         minute;

	modport source (output valid, command, owner_id, day, month, year, hour, minute,
		input ready);
	modport sink (input valid, command, owner_id, day, month, year, hour, minute,
		output ready);
endinterface

interface tpt_rsp_if;
	import tpt_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [OWNER_W-1:0]  out_owner;
	logic [4:0]          out_day;
	logic [3:0]          out_month;
	logic [13:0]         out_year;
	logic [5:0]          out_hour;
	logic [5:0]          out_minute;
	logic [TOTAL_W-1:0]  match_count;
	logic [TOTAL_W-1:0]  entry_total;

	modport source (output valid, status, out_owner, out_day, out_month, out_year,
		out_hour, out_minute, match_count, entry_total, input ready);
	modport sink (input valid, status, out_owner, out_day, out_month, out_year,
		out_hour, out_minute, match_count, entry_total, output ready);
endinterface
`default_nettype wire

[rtl/timestamped_priority_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// sequence: accept, check states CHK1 and CHK2, dispatch, result register for insert, clear
// and unused commands; read earliest, remove earliest, count on date and remove owner add a walk
// over the entries before the result, and remove earliest / remove owner then compact the table
// handshake: one command at a time, next accept in the cycle after the result is registered;
// the result waits in the output state while a previous result is held by rsp.ready low
// reset: arst_n clears the entry count, removal marks and handshake state; entries are not cleared
module timestamped_priority_table_core #(
	parameter int TABLE_DEPTH = tpt_pkg::DEF_TABLE_DEPTH,
	parameter int OWNER_BITS  = tpt_pkg::DEF_OWNER_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	tpt_req_if.sink   req,
	tpt_rsp_if.source rsp
);
	import tpt_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CHK1    = 3'd1;
	localparam logic [2:0] S_CHK2    = 3'd2;
	localparam logic [2:0] S_DISP    = 3'd3;
	localparam logic [2:0] S_WALK    = 3'd4;
	localparam logic [2:0] S_COMPACT = 3'd5;
	localparam logic [2:0] S_OUT     = 3'd6;

	logic [2:0] st_q;

	// captured transaction
	logic [CMD_W-1:0]      cmd_q;
	logic [OWNER_BITS-1:0] own_q;
	key_t                  in_key_q;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] matches_q;

	logic [IW-1:0]         best_idx_q;
	key_t                  best_key_q;
	logic [OWNER_BITS-1:0] best_own_q;

	// result under construction
	logic [STATUS_W-1:0] res_status_q;
	logic [OWNER_W-1:0]  res_own_q;
	key_t                res_key_q;

	// output register
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] o_status_q;
	logic [OWNER_W-1:0]  o_own_q;
	key_t                o_key_q;
	logic [TOTAL_W-1:0]  o_match_q;
	logic [TOTAL_W-1:0]  o_total_q;

	logic date_ok;

	// cell row
	cell_ctl_t             ctl     [TABLE_DEPTH];
	logic [OWNER_BITS-1:0] c_own   [TABLE_DEPTH];
	key_t                  c_key   [TABLE_DEPTH];
	logic                  c_kill  [TABLE_DEPTH];
	logic                  pre_kill[TABLE_DEPTH];

	logic [OWNER_BITS-1:0] cur_own;
	key_t                  cur_key;
	logic                  walk_end, time_ok, ins_ok, own_hit;

	tpt_date_chk u_date (
		.clk   (clk),
		.day   (in_key_q.day),
		.month (in_key_q.month),
		.year  (in_key_q.year),
		.ok    (date_ok)
	);

	// entry at the walk position, one read port over the row
	assign cur_own  = c_own[idx_q[IW-1:0]];
	assign cur_key  = c_key[idx_q[IW-1:0]];
	assign walk_end = (idx_q == cnt_q);
	assign time_ok  = (in_key_q.hour <= 6'd23) && (in_key_q.minute <= 6'd59);
	assign ins_ok   = date_ok && time_ok && (cnt_q != DEPTH_C);
	assign own_hit  = (cur_own == own_q);

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			logic [OWNER_BITS-1:0] nb_own;
			key_t                  nb_key;
			logic                  nb_kill;

			if (gi == TABLE_DEPTH - 1) begin : g_tail
				assign nb_own  = '0;
				assign nb_key  = '0;
				assign nb_kill = 1'b0;
			end else begin : g_link
				assign nb_own  = c_own[gi+1];
				assign nb_key  = c_key[gi+1];
				assign nb_kill = c_kill[gi+1];
			end

			// every cell at or above the lowest marked entry moves down one place
			if (gi == 0) begin : g_pre0
				assign pre_kill[gi] = c_kill[gi];
			end else begin : g_pren
				assign pre_kill[gi] = pre_kill[gi-1] | c_kill[gi];
			end

			always_comb begin
				ctl[gi].wr       = (st_q == S_DISP) && (cmd_q == CMD_INSERT) && ins_ok &&
					(cnt_q == CW'(gi));
				ctl[gi].shift    = (st_q == S_COMPACT) && pre_kill[gi];
				ctl[gi].kill_clr = (st_q == S_DISP);
				ctl[gi].kill_set = (st_q == S_WALK) && (
					(!walk_end && (cmd_q == CMD_DROP_OWNER) && own_hit &&
						(idx_q[IW-1:0] == IW'(gi))) ||
					(walk_end && (cmd_q == CMD_POP_FIRST) && (best_idx_q == IW'(gi))));
			end

			tpt_cell #(.OWNER_BITS(OWNER_BITS)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl[gi]),
				.wr_owner (own_q),
				.wr_key   (in_key_q),
				.nb_owner (nb_own),
				.nb_key   (nb_key),
				.nb_kill  (nb_kill),
				.owner    (c_own[gi]),
				.key      (c_key[gi]),
				.kill     (c_kill[gi])
			);
		end
	endgenerate

	assign req.ready = (st_q == S_IDLE);

	// transaction capture
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q           <= req.command;
			own_q           <= OWNER_BITS'(req.owner_id);
			in_key_q.year   <= req.year;
			in_key_q.month  <= req.month;
			in_key_q.day    <= req.day;
			in_key_q.hour   <= req.hour;
			in_key_q.minute <= req.minute;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && !(st_q == S_OUT)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (req.valid) begin
						st_q <= S_CHK1;
					end
				end
				S_CHK1: begin
					st_q <= S_CHK2;
				end
				S_CHK2: begin
					st_q <= S_DISP;
				end
				S_DISP: begin
					st_q <= S_OUT;
					unique case (cmd_q)
						CMD_INSERT: begin
							if (ins_ok) begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						CMD_READ_FIRST, CMD_POP_FIRST: begin
							if (cnt_q != '0) begin
								st_q <= S_WALK;
							end
						end
						CMD_COUNT_DATE: begin
							if (date_ok) begin
								st_q <= S_WALK;
							end
						end
						CMD_DROP_OWNER: begin
							st_q <= S_WALK;
						end
						CMD_CLEAR: begin
							cnt_q <= '0;
						end
						default: begin
						end
					endcase
				end
				S_WALK: begin
					if (walk_end) begin
						priority if (cmd_q == CMD_POP_FIRST) begin
							cnt_q <= cnt_q - 1'b1;
							st_q  <= S_COMPACT;
						end else if (cmd_q == CMD_DROP_OWNER) begin
							cnt_q <= cnt_q - matches_q;
							st_q  <= S_COMPACT;
						end else begin
							st_q <= S_OUT;
						end
					end
				end
				S_COMPACT: begin
					if (!pre_kill[TABLE_DEPTH-1]) begin
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk datapath and result build-up
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_DISP: begin
				res_status_q <= ST_OK;
				res_own_q    <= '0;
				res_key_q    <= '0;
				matches_q    <= '0;
				idx_q        <= '0;
				best_idx_q   <= '0;
				best_key_q   <= c_key[0];
				best_own_q   <= c_own[0];
				unique case (cmd_q)
					CMD_INSERT: begin
						priority if (!(date_ok && time_ok)) begin
							res_status_q <= ST_INVALID;
						end else if (cnt_q == DEPTH_C) begin
							res_status_q <= ST_FULL;
						end
					end
					CMD_READ_FIRST, CMD_POP_FIRST: begin
						idx_q <= CW'(1);
						if (cnt_q == '0) begin
							res_status_q <= ST_EMPTY;
						end
					end
					CMD_COUNT_DATE: begin
						if (!date_ok) begin
							res_status_q <= ST_INVALID;
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK: begin
				if (walk_end) begin
					if (cmd_q == CMD_READ_FIRST || cmd_q == CMD_POP_FIRST) begin
						res_own_q <= OWNER_W'(best_own_q);
						res_key_q <= best_key_q;
					end
				end else begin
					idx_q <= idx_q + 1'b1;
					unique case (cmd_q)
						CMD_COUNT_DATE: begin
							if (cur_key.year == in_key_q.year &&
								cur_key.month == in_key_q.month &&
								cur_key.day == in_key_q.day) begin
								matches_q <= matches_q + 1'b1;
							end
						end
						CMD_DROP_OWNER: begin
							if (own_hit) begin
								matches_q <= matches_q + 1'b1;
							end
						end
						default: begin
							// strict compare keeps the older entry on a tie
							if (key_bits_t'(cur_key) < key_bits_t'(best_key_q)) begin
								best_key_q <= cur_key;
								best_own_q <= cur_own;
								best_idx_q <= idx_q[IW-1:0];
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if ((st_q == S_OUT) && (!rsp_valid_q || rsp.ready)) begin
			o_status_q <= res_status_q;
			o_own_q    <= res_own_q;
			o_key_q    <= res_key_q;
			o_match_q  <= TOTAL_W'(matches_q);
			o_total_q  <= TOTAL_W'(cnt_q);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = o_status_q;
	assign rsp.out_owner   = o_own_q;
	assign rsp.out_day     = o_key_q.day;
	assign rsp.out_month   = o_key_q.month;
	assign rsp.out_year    = o_key_q.year;
	assign rsp.out_hour    = o_key_q.hour;
	assign rsp.out_minute  = o_key_q.minute;
	assign rsp.match_count = o_match_q;
	assign rsp.entry_total = o_total_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("entry count above table depth");
	a_compact_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_COMPACT) |=> $stable(cnt_q))
		else $error("entry count moved during compaction");
	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (st_q == S_CHK1))
		else $error("accepted transaction not processed");
	a_walk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_WALK) |-> (idx_q <= cnt_q))
		else $error("walk ran past the entry count");
`endif
endmodule
`default_nettype wire

[rtl/tpt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module tpt_cell #(
	parameter int OWNER_BITS = tpt_pkg::DEF_OWNER_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tpt_pkg::cell_ctl_t    ctl,
	input  wire logic [OWNER_BITS-1:0] wr_owner,
	input  wire tpt_pkg::key_t         wr_key,
	input  wire logic [OWNER_BITS-1:0] nb_owner,
	input  wire tpt_pkg::key_t         nb_key,
	input  wire logic                  nb_kill,
	output logic [OWNER_BITS-1:0]      owner,
	output tpt_pkg::key_t              key,
	output logic                       kill
);
	import tpt_pkg::*;

	logic [OWNER_BITS-1:0] owner_q;
	key_t                  key_q;
	logic                  kill_q;

	// entry payload, taken from the upper neighbour during compaction
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			owner_q <= nb_owner;
			key_q   <= nb_key;
		end else if (ctl.wr) begin
			owner_q <= wr_owner;
			key_q   <= wr_key;
		end
	end

	// removal mark travels with its entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kill_q <= 1'b0;
		end else if (ctl.kill_clr) begin
			kill_q <= 1'b0;
		end else if (ctl.shift) begin
			kill_q <= nb_kill;
		end else if (ctl.kill_set) begin
			kill_q <= 1'b1;
		end
	end

	assign owner = owner_q;
	assign key   = key_q;
	assign kill  = kill_q;
endmodule
`default_nettype wire

[rtl/tpt_date_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module tpt_date_chk (
	input  wire logic        clk,
	input  wire logic [4:0]  day,
	input  wire logic [3:0]  month,
	input  wire logic [13:0] year,
	output logic             ok
);
	import tpt_pkg::*;

	// year / 25 by reciprocal, exact for all 14-bit years
	localparam logic [19:0] RECIP25 = 20'd671089;
	localparam int          SHIFT25 = 24;

	logic [33:0] prod;
	logic [9:0]  q_s1;
	logic [14:0] back;
	logic        div25, div4, div16, leap, ok_c;
	logic        ok_s2;

	assign prod = 34'(year) * 34'(RECIP25);

	always_ff @(posedge clk) begin
		q_s1  <= prod[SHIFT25 +: 10];
		ok_s2 <= ok_c;
	end

	always_comb begin
		back  = 15'(q_s1) * 15'd25;
		div25 = (back == {1'b0, year});
		div4  = (year[1:0] == 2'd0);
		div16 = (year[3:0] == 4'd0);
		// divisible by 4 and not by 100, or divisible by 400
		leap  = div4 && (!div25 || div16);
		ok_c  = (year != 14'd0) && (month >= 4'd1) && (month <= 4'd12) &&
			(day != 5'd0) && (day <= month_days(month, leap));
	end

	assign ok = ok_s2;
endmodule
`default_nettype wire
